/* design/itf_pkg.sv */
`default_nettype none
package itf_pkg;

	// sizes
	localparam int VALUE_WIDTH = 64;
	localparam int BUF_DEPTH   = 32;
	localparam int MAX_DIGITS  = 31;
	localparam int WIDTH_SAT   = 32;
	localparam int DIGIT_LIMIT = (BUF_DEPTH - 1 < MAX_DIGITS) ? BUF_DEPTH - 1 : MAX_DIGITS;
	localparam int BUF_IDX_W   = $clog2(BUF_DEPTH);
	localparam int CNT_W       = 6;
	localparam int BIT_W       = $clog2(VALUE_WIDTH);
	localparam int BCD_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int REM_W       = 4 * BCD_DIGITS;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// radix codes
	localparam logic [1:0] RADIX_OCT = 2'd0;
	localparam logic [1:0] RADIX_DEC = 2'd1;
	localparam logic [1:0] RADIX_HEX = 2'd2;

	// characters
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] DIGIT_TEN  = 8'd10;

	// classified word passed from front to back
	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic [1:0]             radix;
		logic                   upper;
		logic                   neg;
		logic [CNT_W-1:0]       width;
		logic                   zfill;
		logic                   left;
		logic [CNT_W-1:0]       prec;
	} item_t;

	// queue handshake toward the back
	typedef struct packed {
		logic  empty;
		item_t head;
	} queue_out_t;

	function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
		logic [7:0] n8;
		n8 = {4'b0000, nib};
		if (n8 < DIGIT_TEN)
			return CH_ZERO + n8;
		else if (upper)
			return CH_UPPER_A + n8 - DIGIT_TEN;
		else
			return CH_LOWER_A + n8 - DIGIT_TEN;
	endfunction

endpackage
`default_nettype wire

/* design/itf_front.sv */
`default_nettype none
module itf_front
	import itf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] magnitude,
	input  wire logic [1:0]  radix_code,
	input  wire logic        upper_case,
	input  wire logic        negative,
	input  wire logic [5:0]  field_width,
	input  wire logic        zero_fill,
	input  wire logic        left_align,
	input  wire logic [4:0]  min_digits,
	input  wire logic        q_full,
	output logic             q_push,
	output item_t            q_item
);

	logic             valid_s1;
	item_t            item_s1;
	item_t            item_c;
	logic [CNT_W-1:0] prec_in;
	logic             accept;

	assign in_stall = valid_s1 & q_full;
	assign accept   = in_valid & ~in_stall;
	assign q_push   = valid_s1 & ~q_full;
	assign q_item   = item_s1;

	// classify: pick base, saturate width and digit count
	always_comb begin
		prec_in       = {1'b0, min_digits};
		item_c.value  = magnitude[VALUE_WIDTH-1:0];
		if (radix_code == RADIX_OCT)
			item_c.radix = RADIX_OCT;
		else if (radix_code == RADIX_DEC)
			item_c.radix = RADIX_DEC;
		else
			item_c.radix = RADIX_HEX;
		item_c.upper  = upper_case;
		item_c.neg    = negative;
		item_c.width  = (field_width > CNT_W'(WIDTH_SAT)) ? CNT_W'(WIDTH_SAT) : field_width;
		item_c.zfill  = zero_fill;
		item_c.left   = left_align;
		item_c.prec   = (prec_in > CNT_W'(DIGIT_LIMIT)) ? CNT_W'(DIGIT_LIMIT) : prec_in;
	end

	// hold the classified word until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_c;
		end
	end

endmodule
`default_nettype wire

/* design/itf_queue.sv */
`default_nettype none
module itf_queue
	import itf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output queue_out_t qout
);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qout.empty = (count_q == '0);
	assign qout.head  = slot_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & ~qout.empty;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

/* design/itf_back.sv */
`default_nettype none
module itf_back
	import itf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire queue_out_t qin,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      text_char,
	output logic            last_char
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DABBLE,
		ST_DIGITS,
		ST_SIZE,
		ST_EMIT
	} state_t;

	localparam int OCT_SHIFT = 3;
	localparam int HEX_SHIFT = 4;

	state_t             state_q;
	item_t              item_q;
	logic [REM_W-1:0]   rem_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [BIT_W-1:0]   bit_q;
	logic [CNT_W-1:0]   dcnt_q;
	logic [CNT_W-1:0]   total_q;
	logic [CNT_W-1:0]   len_q;
	logic [CNT_W-1:0]   pad_q;
	logic [CNT_W-1:0]   pos_q;
	logic               out_valid_q;
	logic [7:0]         char_q;
	logic               last_q;
	logic [7:0]         buf_q [BUF_DEPTH];

	logic [REM_W-1:0]   adj;
	logic [3:0]         nib;
	logic               rem_zero;
	logic               buf_we;
	logic [7:0]         buf_wdata;
	logic               slot_free;
	logic               emit_go;
	logic [CNT_W-1:0]   neg_w;
	logic [CNT_W-1:0]   ndig;
	logic [CNT_W-1:0]   total_c;
	logic [CNT_W-1:0]   dig_idx;
	logic [7:0]         emit_char;
	logic               use_digit;

	assign out_valid = out_valid_q;
	assign text_char = char_q;
	assign last_char = last_q;
	assign q_pop     = (state_q == ST_IDLE) & ~qin.empty;
	assign slot_free = ~out_valid_q | ~out_stall;
	assign emit_go   = (state_q == ST_EMIT) & slot_free;
	assign rem_zero  = (rem_q == '0);
	assign neg_w     = {{(CNT_W-1){1'b0}}, item_q.neg};

	// add three to every BCD digit of five or more
	always_comb begin
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (rem_q[4*d +: 4] >= 4'd5)
				adj[4*d +: 4] = rem_q[4*d +: 4] + 4'd3;
			else
				adj[4*d +: 4] = rem_q[4*d +: 4];
		end
	end

	// low digit of the remaining value
	always_comb begin
		if (item_q.radix == RADIX_OCT)
			nib = {1'b0, rem_q[2:0]};
		else
			nib = rem_q[3:0];
		buf_wdata = rem_zero ? CH_ZERO : digit_char(nib, item_q.upper);
		if (state_q != ST_DIGITS)
			buf_we = 1'b0;
		else if (rem_zero)
			buf_we = (dcnt_q == '0);
		else
			buf_we = (dcnt_q < CNT_W'(DIGIT_LIMIT));
	end

	// field sizes from the digit count
	always_comb begin
		ndig    = (dcnt_q > item_q.prec) ? dcnt_q : item_q.prec;
		total_c = ndig + neg_w;
	end

	// pick the character at the current output position
	always_comb begin
		use_digit = 1'b0;
		emit_char = CH_SPACE;
		if (item_q.left) begin
			dig_idx = total_q - 1'b1 - pos_q;
			if (item_q.neg && pos_q == '0)
				emit_char = CH_MINUS;
			else if (pos_q < total_q)
				use_digit = 1'b1;
			else
				emit_char = CH_SPACE;
		end else if (item_q.zfill) begin
			dig_idx = len_q - 1'b1 - pos_q;
			if (item_q.neg && pos_q == '0)
				emit_char = CH_MINUS;
			else if (pos_q < neg_w + pad_q)
				emit_char = CH_ZERO;
			else
				use_digit = 1'b1;
		end else begin
			dig_idx = len_q - 1'b1 - pos_q;
			if (pos_q < pad_q)
				emit_char = CH_SPACE;
			else if (item_q.neg && pos_q == pad_q)
				emit_char = CH_MINUS;
			else
				use_digit = 1'b1;
		end
	end

	// sequencer: convert, count digits, size the field, send characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			rem_q       <= '0;
			val_q       <= '0;
			bit_q       <= '0;
			dcnt_q      <= '0;
			total_q     <= '0;
			len_q       <= '0;
			pad_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			// raise valid on a new character, drop it once taken
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!qin.empty) begin
						item_q <= qin.head;
						dcnt_q <= '0;
						bit_q  <= '0;
						if (qin.head.radix == RADIX_DEC) begin
							rem_q   <= '0;
							val_q   <= qin.head.value;
							state_q <= ST_DABBLE;
						end else begin
							rem_q   <= REM_W'(qin.head.value);
							state_q <= ST_DIGITS;
						end
					end
				end
				ST_DABBLE: begin
					rem_q <= {adj[REM_W-2:0], val_q[VALUE_WIDTH-1]};
					val_q <= val_q << 1;
					bit_q <= bit_q + 1'b1;
					if (bit_q == BIT_W'(VALUE_WIDTH - 1))
						state_q <= ST_DIGITS;
				end
				ST_DIGITS: begin
					if (buf_we) begin
						dcnt_q <= dcnt_q + 1'b1;
						if (item_q.radix == RADIX_OCT)
							rem_q <= rem_q >> OCT_SHIFT;
						else
							rem_q <= rem_q >> HEX_SHIFT;
					end else begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					total_q <= total_c;
					if (item_q.width > total_c) begin
						len_q <= item_q.width;
						pad_q <= item_q.width - total_c;
					end else begin
						len_q <= total_c;
						pad_q <= '0;
					end
					pos_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (!use_digit)
							char_q <= emit_char;
						else if (dig_idx >= dcnt_q)
							char_q <= CH_ZERO;
						else
							char_q <= buf_q[dig_idx[BUF_IDX_W-1:0]];
						last_q      <= (pos_q == len_q - 1'b1);
						pos_q       <= pos_q + 1'b1;
						if (pos_q == len_q - 1'b1)
							state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// digit buffer, filled least significant digit first
	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_q[dcnt_q[BUF_IDX_W-1:0]] <= buf_wdata;
		end
	end

endmodule
`default_nettype wire

/* design/integer_to_text_formatter_core.sv */
`default_nettype none
// Integer-to-text formatter: takes one word describing an unsigned magnitude with
// its base, case, sign, field width, zero-fill, left-align and minimum digit count,
// and sends the formatted ASCII text one character per output word, with last_char
// set on the final character. A front stage classifies each word into a two-entry
// queue, so the input side keeps accepting while the back end works, until the queue
// and the front register are full. The back end handles one word at a time: it loads
// the word, then for decimal runs a binary-to-BCD shift over all VALUE_WIDTH (64) bits,
// then extracts the digits into a buffer, sizes the field, and sends the characters
// (field width or text length, up to 32), one per cycle while out_stall is low.
module integer_to_text_formatter_core
	import itf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] magnitude,
	input  wire logic [1:0]  radix_code,
	input  wire logic        upper_case,
	input  wire logic        negative,
	input  wire logic [5:0]  field_width,
	input  wire logic        zero_fill,
	input  wire logic        left_align,
	input  wire logic [4:0]  min_digits,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       text_char,
	output logic             last_char
);

	logic       q_full;
	logic       q_push;
	item_t      q_item;
	logic       q_pop;
	queue_out_t q_out;

	// accept and classify words
	itf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.magnitude   (magnitude),
		.radix_code  (radix_code),
		.upper_case  (upper_case),
		.negative    (negative),
		.field_width (field_width),
		.zero_fill   (zero_fill),
		.left_align  (left_align),
		.min_digits  (min_digits),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_item)
	);

	// decouple front and back
	itf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.qout      (q_out)
	);

	// convert and send characters
	itf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qin       (q_out),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.text_char (text_char),
		.last_char (last_char)
	);

endmodule
`default_nettype wire
